// ===== design/account_ledger_table_top_defines.svh =====
// Assertion macros shared by the account ledger table RTL.
// Each macro expects clk_i and rst_ni to be visible in the including module.
`ifndef ACCOUNT_LEDGER_TABLE_TOP_DEFINES_SVH
`define ACCOUNT_LEDGER_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define ALT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define ALT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/alt_pkg.sv =====
// Shared types and constants of the account ledger table.
// No dependencies; used by alt_alu and account_ledger_table_top.
`default_nettype none

package alt_pkg;

  localparam int unsigned VAL_W      = 64;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned IDX_OUT_W  = 8;
  localparam int unsigned IN_DATA_W  = 3 * VAL_W;
  localparam int unsigned OUT_RAW_W  = STATUS_W + IDX_OUT_W + 1 + 2 * VAL_W;
  localparam int unsigned OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREDIT    = 2'd0,
    KIND_DEBIT     = 2'd1,
    KIND_CHK_NONCE = 2'd2,
    KIND_INC_NONCE = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_INSUF     = 3'd2,
    STATUS_NONCE_BAD = 3'd3,
    STATUS_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_EXEC   = 2'd2
  } state_e;

endpackage

`default_nettype wire

// ===== design/alt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module alt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/alt_alu.sv =====
// Balance and nonce update for one ledger operation.
// Depends on alt_pkg for the operation and status codes.
`default_nettype none

module alt_alu (
  input  wire alt_pkg::kind_e           kind_i,
  input  wire logic [alt_pkg::VAL_W-1:0] amount_i,
  input  wire logic [alt_pkg::VAL_W-1:0] nonce_in_i,
  input  wire logic [alt_pkg::VAL_W-1:0] bal_i,
  input  wire logic [alt_pkg::VAL_W-1:0] nonce_i,
  output alt_pkg::status_e              status_o,
  output logic      [alt_pkg::VAL_W-1:0] bal_o,
  output logic      [alt_pkg::VAL_W-1:0] nonce_o
);

  import alt_pkg::*;

  logic [VAL_W:0] sum;

  assign sum = {1'b0, bal_i} + {1'b0, amount_i};

  always_comb begin
    status_o = STATUS_OK;
    bal_o    = bal_i;
    nonce_o  = nonce_i;
    case (kind_i)
      KIND_CREDIT: begin
        // A carry out of the top bit means the credit does not fit.
        if (sum[VAL_W]) begin
          status_o = STATUS_OVERFLOW;
        end else begin
          bal_o = sum[VAL_W-1:0];
        end
      end
      KIND_DEBIT: begin
        if (bal_i < amount_i) begin
          status_o = STATUS_INSUF;
        end else begin
          bal_o = bal_i - amount_i;
        end
      end
      KIND_CHK_NONCE: begin
        if (nonce_in_i != nonce_i) begin
          status_o = STATUS_NONCE_BAD;
        end
      end
      KIND_INC_NONCE: begin
        nonce_o = nonce_i + VAL_W'(1);
      end
      default: begin
        status_o = STATUS_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/account_ledger_table_top.sv =====
// A word is accepted in ST_IDLE; ST_SEARCH then reads the stored keys from slot 0 on, at most
// TABLE_ENTRIES of them, and compares each with the item's key up to a match or the last filled entry.
// One item is in flight at a time and the next word is taken in the cycle after the result is
// loaded in ST_EXEC, which waits while the output register holds a word that is not yet taken.
// Reset clears the fill count, the control state and the output valid; memories are not cleared.
// Depends on alt_pkg, alt_ram, alt_alu and account_ledger_table_top_defines.svh.
`default_nettype none

`include "account_ledger_table_top_defines.svh"

module account_ledger_table_top #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned KEY_BITS      = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input words.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0: address_key[63:0], amount[63:0], nonce_in[63:0].
  input  wire logic [alt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser from bit 0: kind[1:0].
  input  wire logic [alt_pkg::KIND_W-1:0]        s_axis_tuser,
  // Result words.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata from bit 0: status[2:0], entry_index[7:0], created, balance_now[63:0],
  // nonce_now[63:0], then zero padding up to a whole byte.
  output logic      [alt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  import alt_pkg::*;

  // Slot index width and fill-count width (the count must be able to hold the depth).
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned DATA_W = 2 * VAL_W;

  // Control state.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              out_vld_q, out_vld_d;

  // Item and search payload registers.
  kind_e             kind_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]  amount_q, nonce_in_q;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              made_q, made_d;
  logic              full_q, full_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Memory ports.
  logic              key_we, key_re;
  logic [IDX_W-1:0]  key_raddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic              data_we, data_re;
  logic [DATA_W-1:0] data_rdata;

  // Operation unit.
  logic [VAL_W-1:0]  bal_cur, nonce_cur, bal_new, nonce_new;
  status_e           alu_status;

  logic              in_accept;
  logic              hit;
  logic              out_free;
  logic              out_load;
  logic [IDX_OUT_W-1:0] slot_ext;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // The key read in the previous cycle is compared against the item's key.
  assign hit      = cmp_vld_q && (key_rdata == key_q);
  assign out_free = !out_vld_q || m_axis_tready;

  // A freshly made entry starts at balance zero and nonce zero.
  assign bal_cur   = made_q ? '0 : data_rdata[VAL_W-1:0];
  assign nonce_cur = made_q ? '0 : data_rdata[DATA_W-1:VAL_W];

  // The reported slot is taken modulo 256.
  assign slot_ext = IDX_OUT_W'(slot_q);

  alt_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (key_q),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Balance in the low half, nonce in the high half.
  alt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot_q),
    .wdata_i ({nonce_new, bal_new}),
    .re_i    (data_re),
    .raddr_i (cmp_idx_q),
    .rdata_o (data_rdata)
  );

  alt_alu u_alu (
    .kind_i     (kind_q),
    .amount_i   (amount_q),
    .nonce_in_i (nonce_in_q),
    .bal_i      (bal_cur),
    .nonce_i    (nonce_cur),
    .status_o   (alu_status),
    .bal_o      (bal_new),
    .nonce_o    (nonce_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q     <= kind_e'(s_axis_tuser);
      key_q      <= s_axis_tdata[KEY_BITS-1:0];
      amount_q   <= s_axis_tdata[2*VAL_W-1:VAL_W];
      nonce_in_q <= s_axis_tdata[3*VAL_W-1:2*VAL_W];
    end
    idx_q      <= idx_d;
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    made_q     <= made_d;
    full_q     <= full_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = cmp_vld_q;
    idx_d      = idx_q;
    cmp_idx_d  = cmp_idx_q;
    slot_d     = slot_q;
    made_d     = made_q;
    full_d     = full_q;
    out_data_d = out_data_q;
    key_we     = 1'b0;
    key_re     = 1'b0;
    key_raddr  = idx_q[IDX_W-1:0];
    data_we    = 1'b0;
    data_re    = 1'b0;
    out_load   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          state_d   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          // Match: fetch the entry's balance and nonce for the update.
          slot_d    = cmp_idx_q;
          made_d    = 1'b0;
          full_d    = 1'b0;
          data_re   = 1'b1;
          cmp_vld_d = 1'b0;
          state_d   = ST_EXEC;
        end else if (idx_q < cnt_q) begin
          // Keep streaming stored keys, one per cycle.
          key_re    = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IDX_W-1:0];
          idx_d     = idx_q + CNT_W'(1);
        end else begin
          cmp_vld_d = 1'b0;
          if (!cmp_vld_q) begin
            // Every filled key has been compared without a match.
            state_d = ST_EXEC;
            if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
              full_d = 1'b1;
              made_d = 1'b0;
            end else begin
              full_d = 1'b0;
              made_d = 1'b1;
              slot_d = cnt_q[IDX_W-1:0];
              key_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          data_we  = !full_q;
          state_d  = ST_IDLE;
          if (full_q) begin
            out_data_d = OUT_DATA_W'(STATUS_FULL);
          end else begin
            out_data_d = OUT_DATA_W'({nonce_new, bal_new, made_q, slot_ext, alu_status});
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // The fill count never passes the table depth.
  `ALT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(TABLE_ENTRIES), "fill count above depth")
  // A new key is only written at the end of a search, and it grows the fill count by one.
  `ALT_ASSERT_IMP(a_key_we_state, key_we, state_q == ST_SEARCH && !hit,
                  "key written outside a missed search")
  `ALT_ASSERT_NXT(a_key_we_cnt, key_we, cnt_q == $past(cnt_q) + CNT_W'(1),
                  "fill count did not follow key write")
  // A table-full result never writes the data memory.
  `ALT_ASSERT_IMP(a_full_no_write, state_q == ST_EXEC && full_q, !data_we,
                  "data written on a full table")
  // A result is loaded only when the output register can take it.
  `ALT_ASSERT_IMP(a_out_no_overrun, out_vld_q && !m_axis_tready, !out_load,
                  "result overwrote a pending word")

endmodule

`default_nettype wire
